// ----- src/rrfp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rrfp_pkg;

   // Report header and footer sequences, in order of arrival.
   localparam logic [7:0] HEAD_SEQ [4] = '{8'hF4, 8'hF3, 8'hF2, 8'hF1};
   localparam logic [7:0] TAIL_SEQ [4] = '{8'hF8, 8'hF7, 8'hF6, 8'hF5};

   localparam logic [7:0] HEAD_MARK = 8'hAA;
   localparam logic [7:0] TAIL_MARK = 8'h55;
   localparam logic [7:0] TYPE_BASIC = 8'h02;
   localparam logic [7:0] TYPE_ENG = 8'h01;

   localparam int BODY_BASIC = 13;
   localparam int BODY_ENG = 35;
   localparam int BASIC_TOTAL = 6 + BODY_BASIC + 4;
   localparam int ENG_TOTAL = 6 + BODY_ENG + 4;

   // Window of the latest bytes seen at the final byte of a frame: the final
   // byte itself plus a shift line holding the rest of the longest body and its footer.
   localparam int WIN_LEN = ENG_TOTAL - 6;
   localparam int SHIFT_LEN = WIN_LEN - 1;

   localparam int GATE_COUNT = 9;
   localparam int IDX_W = $clog2(GATE_COUNT + 1);

   localparam logic [1:0] KIND_BASIC = 2'd0;
   localparam logic [1:0] KIND_ENG = 2'd1;
   localparam logic [1:0] KIND_GATE = 2'd2;

   typedef struct packed {
      logic                        eng;
      logic [7:0]                  target_state;
      logic [15:0]                 moving_distance;
      logic [7:0]                  moving_strength;
      logic [15:0]                 static_distance;
      logic [7:0]                  static_strength;
      logic [15:0]                 detect_distance;
      logic [31:0]                 extras;
      logic [GATE_COUNT-1:0][7:0]  gate_moving;
      logic [GATE_COUNT-1:0][7:0]  gate_static;
   } frame_rec_type;

endpackage

`default_nettype wire

// ----- src/rrfp_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrfp_parser #(
   parameter int FRAME_BYTES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   byte_accept,
   input  wire logic [7:0]             rx_byte,
   output logic                        at_last,
   output logic                        frame_load,
   output rrfp_pkg::frame_rec_type     frame_rec
);

   localparam int POS_W = $clog2(FRAME_BYTES + 1);
   localparam logic [15:0] LEN_LIMIT = 16'(FRAME_BYTES - 10);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;

   localparam int EB = rrfp_pkg::ENG_TOTAL - 1;
   localparam int BB = rrfp_pkg::BASIC_TOTAL - 1;

   logic [1:0]       phase_ff, phase_in;
   logic [1:0]       match_ff, match_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [7:0]       shift_ff [rrfp_pkg::SHIFT_LEN];
   logic [7:0]       win [rrfp_pkg::WIN_LEN];
   logic [15:0]      len_word;
   logic             eng_len, basic_len, footer_ok, basic_ok, eng_ok;

   assign len_word = {rx_byte, len_lo_ff};

   assign at_last = (phase_ff != PH_HUNT) && (phase_ff != PH_LEN) &&
                    (({1'b0, pos_ff} + (POS_W + 1)'(1)) >= {1'b0, total_ff});

   always_comb begin
      win[0] = rx_byte;
      for (int k = 1; k < rrfp_pkg::WIN_LEN; k++) begin
         win[k] = shift_ff[k-1];
      end
   end

   // With the final byte at window slot 0, frame position p sits at slot
   // total - 1 - p, so every field is at a fixed slot for each frame type.
   assign basic_len = (total_ff == POS_W'(rrfp_pkg::BASIC_TOTAL));
   assign eng_len = (total_ff == POS_W'(rrfp_pkg::ENG_TOTAL));
   assign footer_ok = (win[3] == rrfp_pkg::TAIL_SEQ[0]) && (win[2] == rrfp_pkg::TAIL_SEQ[1]) &&
                      (win[1] == rrfp_pkg::TAIL_SEQ[2]) && (win[0] == rrfp_pkg::TAIL_SEQ[3]);
   assign basic_ok = basic_len && (win[BB-6] == rrfp_pkg::TYPE_BASIC) &&
                     (win[BB-7] == rrfp_pkg::HEAD_MARK) && (win[BB-17] == rrfp_pkg::TAIL_MARK);
   assign eng_ok = eng_len && (win[EB-6] == rrfp_pkg::TYPE_ENG) &&
                   (win[EB-7] == rrfp_pkg::HEAD_MARK) && (win[EB-39] == rrfp_pkg::TAIL_MARK);

   assign frame_load = byte_accept && at_last && footer_ok && (basic_ok || eng_ok);

   always_comb begin
      frame_rec.eng = eng_len;
      frame_rec.target_state = eng_len ? win[EB-8] : win[BB-8];
      frame_rec.moving_distance = eng_len ? {win[EB-10], win[EB-9]} : {win[BB-10], win[BB-9]};
      frame_rec.moving_strength = eng_len ? win[EB-11] : win[BB-11];
      frame_rec.static_distance = eng_len ? {win[EB-13], win[EB-12]} : {win[BB-13], win[BB-12]};
      frame_rec.static_strength = eng_len ? win[EB-14] : win[BB-14];
      frame_rec.detect_distance = eng_len ? {win[EB-16], win[EB-15]} : {win[BB-16], win[BB-15]};
      frame_rec.extras = eng_len ? {win[EB-38], win[EB-37], win[EB-18], win[EB-17]} : 32'd0;
      for (int k = 0; k < rrfp_pkg::GATE_COUNT; k++) begin
         frame_rec.gate_moving[k] = win[EB-19-k];
         frame_rec.gate_static[k] = win[EB-28-k];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      pos_in = pos_ff;
      total_in = total_ff;
      len_lo_in = len_lo_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == rrfp_pkg::HEAD_SEQ[match_ff]) begin
                  if (match_ff == 2'd3) begin
                     phase_in = PH_LEN;
                     pos_in = POS_W'(4);
                     match_in = 2'd0;
                  end else begin
                     match_in = match_ff + 2'd1;
                  end
               end else begin
                  match_in = (rx_byte == rrfp_pkg::HEAD_SEQ[0]) ? 2'd1 : 2'd0;
               end
            end
            PH_LEN: begin
               if (pos_ff == POS_W'(4)) begin
                  len_lo_in = rx_byte;
                  pos_in = POS_W'(5);
               end else if (len_word > LEN_LIMIT) begin
                  phase_in = PH_HUNT;
                  pos_in = '0;
                  total_in = '0;
               end else begin
                  phase_in = PH_BODY;
                  pos_in = POS_W'(6);
                  total_in = len_word[POS_W-1:0] + POS_W'(10);
               end
            end
            default: begin
               pos_in = pos_ff + POS_W'(1);
               if (at_last) begin
                  phase_in = PH_HUNT;
                  pos_in = '0;
                  total_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         match_ff <= 2'd0;
         pos_ff <= '0;
         total_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         pos_ff <= pos_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      len_lo_ff <= len_lo_in;
      if (byte_accept) begin
         shift_ff[0] <= rx_byte;
         for (int k = 1; k < rrfp_pkg::SHIFT_LEN; k++) begin
            shift_ff[k] <= shift_ff[k-1];
         end
      end
   end

   a_body_pos_below_total: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (pos_ff < total_ff))
      else $error("body position reached the frame total");

   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEN) |-> (pos_ff == POS_W'(4) || pos_ff == POS_W'(5)))
      else $error("length phase at an unexpected position");

   a_hunt_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (pos_ff == '0 && total_ff == '0))
      else $error("frame position left over while hunting for a header");

endmodule

`default_nettype wire

// ----- src/rrfp_emitter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rrfp_emitter (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    frame_load,
   input  wire rrfp_pkg::frame_rec_type frame_rec,
   output logic                         busy,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [1:0]                   rsp_record_kind,
   output logic                         rsp_last_of_run,
   output logic [7:0]                   rsp_target_state,
   output logic [15:0]                  rsp_moving_distance,
   output logic [7:0]                   rsp_moving_strength,
   output logic [15:0]                  rsp_static_distance,
   output logic [7:0]                   rsp_static_strength,
   output logic [15:0]                  rsp_detect_distance,
   output logic [31:0]                  rsp_engineering_extras,
   output logic [3:0]                   rsp_gate_index,
   output logic [7:0]                   rsp_gate_moving_strength,
   output logic [7:0]                   rsp_gate_static_strength
);

   localparam int IW = rrfp_pkg::IDX_W;

   logic                    rec_valid_ff;
   logic [IW-1:0]           idx_ff;
   rrfp_pkg::frame_rec_type rec_ff;
   logic                    is_summary, is_last, done;
   logic [IW-1:0]           gsel;

   assign is_summary = (idx_ff == '0);
   assign gsel = idx_ff - IW'(1);
   assign is_last = is_summary ? !rec_ff.eng : (idx_ff == IW'(rrfp_pkg::GATE_COUNT));
   assign done = rec_valid_ff && rsp_ready;

   assign busy = rec_valid_ff;
   assign rsp_valid = rec_valid_ff;
   assign rsp_last_of_run = is_last;

   always_comb begin
      if (is_summary) begin
         rsp_record_kind = rec_ff.eng ? rrfp_pkg::KIND_ENG : rrfp_pkg::KIND_BASIC;
         rsp_target_state = rec_ff.target_state;
         rsp_moving_distance = rec_ff.moving_distance;
         rsp_moving_strength = rec_ff.moving_strength;
         rsp_static_distance = rec_ff.static_distance;
         rsp_static_strength = rec_ff.static_strength;
         rsp_detect_distance = rec_ff.detect_distance;
         rsp_engineering_extras = rec_ff.extras;
         rsp_gate_index = 4'd0;
         rsp_gate_moving_strength = 8'd0;
         rsp_gate_static_strength = 8'd0;
      end else begin
         rsp_record_kind = rrfp_pkg::KIND_GATE;
         rsp_target_state = 8'd0;
         rsp_moving_distance = 16'd0;
         rsp_moving_strength = 8'd0;
         rsp_static_distance = 16'd0;
         rsp_static_strength = 8'd0;
         rsp_detect_distance = 16'd0;
         rsp_engineering_extras = 32'd0;
         rsp_gate_index = 4'(gsel);
         rsp_gate_moving_strength = rec_ff.gate_moving[gsel];
         rsp_gate_static_strength = rec_ff.gate_static[gsel];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else if (frame_load) begin
         rec_valid_ff <= 1'b1;
         idx_ff <= '0;
      end else if (done) begin
         if (is_last) begin
            rec_valid_ff <= 1'b0;
            idx_ff <= '0;
         end else begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_load) begin
         rec_ff <= frame_rec;
      end
   end

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      frame_load |-> !rec_valid_ff)
      else $error("frame loaded over a run still draining");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (done && is_last) |=> !rec_valid_ff)
      else $error("record still valid after its final transfer");

   a_basic_single: assert property (@(posedge clock) disable iff (reset)
      (rec_valid_ff && !rec_ff.eng) |-> is_summary)
      else $error("basic frame produced a gate row");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rec_valid_ff |-> (idx_ff <= IW'(rrfp_pkg::GATE_COUNT)))
      else $error("gate row index out of range");

endmodule

`default_nettype wire

// ----- src/radar_report_frame_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Carries
// req_      in         req_valid / req_ready    req_rx_byte: one received serial byte
// rsp_      out        rsp_valid / rsp_ready    one summary or gate row of a valid frame
//
// One byte is taken per cycle while req_ready is high; the frame is checked in the
// cycle its final byte is transferred and the result run is registered at the next edge.
// A basic frame gives one result, an engineering frame a summary and nine gate
// rows, one per cycle while rsp_ready is high.
// Bytes keep flowing while results drain; only the final byte of a frame waits
// while the previous frame's run is still being transferred.
// Synchronous reset returns the parser to header hunting and empties the result.

module radar_report_frame_parser #(
   parameter int FRAME_BYTES = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_rx_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [1:0]        rsp_record_kind,
   output logic              rsp_last_of_run,
   output logic [7:0]        rsp_target_state,
   output logic [15:0]       rsp_moving_distance,
   output logic [7:0]        rsp_moving_strength,
   output logic [15:0]       rsp_static_distance,
   output logic [7:0]        rsp_static_strength,
   output logic [15:0]       rsp_detect_distance,
   output logic [31:0]       rsp_engineering_extras,
   output logic [3:0]        rsp_gate_index,
   output logic [7:0]        rsp_gate_moving_strength,
   output logic [7:0]        rsp_gate_static_strength
);

   logic                    byte_accept;
   logic                    at_last;
   logic                    frame_load;
   logic                    busy;
   rrfp_pkg::frame_rec_type frame_rec;

   // Only a byte that could complete a frame needs the result register free;
   // the decision depends on parser state alone, never on the incoming byte.
   assign req_ready = !(at_last && busy);
   assign byte_accept = req_valid && req_ready;

   rrfp_parser #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_parser (
      .clock(clock),
      .reset(reset),
      .byte_accept(byte_accept),
      .rx_byte(req_rx_byte),
      .at_last(at_last),
      .frame_load(frame_load),
      .frame_rec(frame_rec)
   );

   rrfp_emitter u_emitter (
      .clock(clock),
      .reset(reset),
      .frame_load(frame_load),
      .frame_rec(frame_rec),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_record_kind(rsp_record_kind),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_target_state(rsp_target_state),
      .rsp_moving_distance(rsp_moving_distance),
      .rsp_moving_strength(rsp_moving_strength),
      .rsp_static_distance(rsp_static_distance),
      .rsp_static_strength(rsp_static_strength),
      .rsp_detect_distance(rsp_detect_distance),
      .rsp_engineering_extras(rsp_engineering_extras),
      .rsp_gate_index(rsp_gate_index),
      .rsp_gate_moving_strength(rsp_gate_moving_strength),
      .rsp_gate_static_strength(rsp_gate_static_strength)
   );

endmodule

`default_nettype wire
